// File: hw/rtl/bba_pkg.sv
// Shared types and constants of the buddy block allocator.
// Holds the FSM state type, status codes and block mark encodings.
// No dependencies.
package bba_pkg;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DEC,
		S_SCAN_A,
		S_SEG,
		S_SPLIT_RD,
		S_SPLIT_WR,
		S_SCAN_E,
		S_MARK,
		S_MERGE,
		S_DONE
	} state_t;

	localparam logic [2:0] STAT_OK      = 3'd0;
	localparam logic [2:0] STAT_TOO_BIG = 3'd1;
	localparam logic [2:0] STAT_NOSPACE = 3'd2;
	localparam logic [2:0] STAT_BAD_OFF = 3'd3;
	localparam logic [2:0] STAT_BAD_CFG = 3'd4;

	localparam logic FUNC_FREE = 1'b1;

	// mark bit 0: allocated, bit 1: end of block
	localparam int MARK_ALLOC_BIT = 0;
	localparam int MARK_END_BIT   = 1;
	localparam logic [1:0] MARK_NONE  = 2'b00;
	localparam logic [1:0] MARK_ALLOC = 2'b01;
	localparam logic [1:0] MARK_END   = 2'b10;

	localparam logic REG_MIN_ORDER  = 1'b0;
	localparam logic REG_HEAP_ORDER = 1'b1;

	typedef struct packed {
		logic is_free;
		logic too_large;
		logic bad_off;
	} dec_flags_t;

endpackage

// File: hw/rtl/bba_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bba_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/bba_req_dec.sv
// Request decoder: rounds the allocate size to a block order and turns the
// free offset into a block index. Registered on the accepted beat.
// Depends on bba_pkg.
module bba_req_dec #(
	parameter int LOG_MAX_BLOCKS = 8,
	localparam int IW = LOG_MAX_BLOCKS,
	localparam int CW = LOG_MAX_BLOCKS + 1,
	localparam int OW = $clog2(LOG_MAX_BLOCKS + 1)
) (
	input  logic                clk,
	input  logic                en,
	input  logic                func,
	input  logic [31:0]         request_bytes,
	input  logic [31:0]         free_offset,
	input  logic [4:0]          min_order,
	input  logic [5:0]          heap_order,
	input  logic [CW-1:0]       n,
	output bba_pkg::dec_flags_t flags,
	output logic [OW-1:0]       c,
	output logic [IW-1:0]       fidx
);
	import bba_pkg::*;

	logic [31:0] xm1;
	logic [5:0]  k;
	logic [5:0]  km;
	logic [5:0]  min6;
	logic [31:0] shifted;

	dec_flags_t    flags_q;
	logic [OW-1:0] c_q;
	logic [IW-1:0] fidx_q;

	assign xm1     = request_bytes - 32'd1;
	assign min6    = {1'b0, min_order};
	assign shifted = free_offset >> min_order;

	// bit length of size - 1 gives the rounded order
	always_comb begin
		k = '0;
		for (int b = 0; b < 32; b++) begin
			if (xm1[b]) begin
				k = 6'(b + 1);
			end
		end
		if (request_bytes == 32'd0) begin
			k = '0;
		end
	end

	assign km = (k < min6) ? min6 : k;

	always_ff @(posedge clk) begin
		if (en) begin
			flags_q.is_free   <= (func == FUNC_FREE);
			flags_q.too_large <= (km > heap_order);
			flags_q.bad_off   <= (shifted >= 32'(n));
			c_q               <= OW'(km - min6);
			fidx_q            <= shifted[IW-1:0];
		end
	end

	assign flags = flags_q;
	assign c     = c_q;
	assign fidx  = fidx_q;

endmodule

// File: hw/rtl/buddy_block_allocator.sv
// Buddy block allocator: top level and request sequencer; needs bba_pkg, bba_ram, bba_req_dec.
// Throughput: one request at a time, set by the single read port of the mark memory.
// Reset and every register write start a clearing pass over all 2^LOG_MAX_BLOCKS mark entries;
// no request is taken then.
module buddy_block_allocator #(
	parameter int LOG_MAX_BLOCKS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [5:0]  wr_data,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [31:0] request_bytes,
	input  logic [31:0] free_offset,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] offset,
	output logic [8:0]  blocks
);
	import bba_pkg::*;

	localparam int MAXB = 1 << LOG_MAX_BLOCKS;
	localparam int IW   = LOG_MAX_BLOCKS;
	localparam int CW   = LOG_MAX_BLOCKS + 1;
	localparam int OW   = $clog2(LOG_MAX_BLOCKS + 1);
	localparam int SW   = $clog2(LOG_MAX_BLOCKS + 2);

	// configuration
	logic [4:0]    min_q;
	logic [5:0]    heap_q;
	logic [5:0]    diff;
	logic          cfg_ok;
	logic [OW-1:0] ordn;
	logic [CW-1:0] n;
	logic [IW-1:0] nm1;

	assign diff   = heap_q - {1'b0, min_q};
	assign cfg_ok = (heap_q <= 6'd32) && (heap_q >= {1'b0, min_q}) &&
	                (diff <= 6'(LOG_MAX_BLOCKS));
	assign ordn   = cfg_ok ? diff[OW-1:0] : '0;
	assign n      = cfg_ok ? (CW'(1) << ordn) : '0;
	assign nm1    = IW'(n - CW'(1));

	// sequencer registers
	state_t        state_q, state_d;
	logic [CW-1:0] rd_q, rd_d;
	logic          v_s1;
	logic [IW-1:0] j_s1;
	logic [CW-1:0] run_q, run_d;
	logic          wok_q, wok_d;
	logic          wfound_q, wfound_d;
	logic [IW-1:0] wst_q, wst_d;
	logic [IW-1:0] seg_q, seg_d;
	logic [IW-1:0] base_q, base_d;
	logic [CW-1:0] cc_q, cc_d;
	logic [SW-1:0] s_q, s_d;
	logic          any_q, any_d;
	logic [SW-1:0] lw_q, lw_d;
	logic [CW-1:0] clr_q, clr_d;
	logic [OW-1:0] c_q, c_d;
	logic [2:0]    rs_q, rs_d;
	logic [31:0]   ro_q, ro_d;
	logic [8:0]    rb_q, rb_d;
	logic          out_valid_q;
	logic [2:0]    out_status_q;
	logic [31:0]   out_off_q;
	logic [8:0]    out_blk_q;
	logic          issue;
	logic          load_out;
	logic          accept;

	// memory port
	logic          we;
	logic [IW-1:0] waddr;
	logic [1:0]    wdata;
	logic [IW-1:0] raddr;
	logic [1:0]    rdata;

	// decoder outputs
	dec_flags_t    dflags;
	logic [OW-1:0] dec_c;
	logic [IW-1:0] dec_fidx;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	bba_ram #(
		.WIDTH(2),
		.DEPTH(MAXB)
	) u_marks (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	bba_req_dec #(
		.LOG_MAX_BLOCKS(LOG_MAX_BLOCKS)
	) u_dec (
		.clk          (clk),
		.en           (accept),
		.func         (func),
		.request_bytes(request_bytes),
		.free_offset  (free_offset),
		.min_order    (min_q),
		.heap_order   (heap_q),
		.n            (n),
		.flags        (dflags),
		.c            (dec_c),
		.fidx         (dec_fidx)
	);

	// next state, memory control and datapath updates
	always_comb begin
		logic [CW-1:0] count;
		logic [IW-1:0] mask;
		logic          fr;
		logic [CW-1:0] run_n;
		logic          last;
		logic          hit;
		logic [IW-1:0] pos;
		logic          ok_n;
		logic          hitw;
		logic [IW-1:0] wstart;
		logic [CW-1:0] cc_n;
		logic [CW-1:0] sh;
		logic [CW-1:0] sh_m1;
		logic [IW-1:0] e;
		logic [CW-1:0] w;
		logic [IW-1:0] wm;
		logic          any_n;
		logic [SW-1:0] lw_n;

		count  = CW'(1) << c_q;
		mask   = IW'(count - CW'(1));
		fr     = !rdata[MARK_ALLOC_BIT];
		run_n  = fr ? (run_q + CW'(1)) : '0;
		last   = (j_s1 == nm1);
		hit    = rdata[MARK_END_BIT] && fr && (run_n == count);
		pos    = j_s1 & mask;
		ok_n   = ((pos == '0) || wok_q) && (rdata == MARK_NONE);
		hitw   = (state_q == S_SCAN_A) && (pos == mask) && ok_n && !wfound_q;
		wstart = j_s1 & ~mask;
		cc_n   = cc_q + CW'(1);
		sh     = cc_q >> s_q;
		sh_m1  = sh - CW'(1);
		e      = seg_q + sh_m1[IW-1:0];
		w      = CW'(1) << lw_q;
		wm     = IW'(w - CW'(1));
		any_n  = ((j_s1 & wm) != '0 && any_q) || rdata[MARK_ALLOC_BIT];
		lw_n   = lw_q + SW'(1);

		state_d  = state_q;
		rd_d     = rd_q;
		issue    = 1'b0;
		raddr    = rd_q[IW-1:0];
		we       = 1'b0;
		waddr    = j_s1;
		wdata    = MARK_NONE;
		run_d    = run_q;
		wok_d    = wok_q;
		wfound_d = wfound_q;
		wst_d    = wst_q;
		seg_d    = seg_q;
		base_d   = base_q;
		cc_d     = cc_q;
		s_d      = s_q;
		any_d    = any_q;
		lw_d     = lw_q;
		clr_d    = clr_q;
		c_d      = c_q;
		rs_d     = rs_q;
		ro_d     = ro_q;
		rb_d     = rb_q;
		load_out = 1'b0;

		unique case (state_q)
			S_CLEAR: begin
				// sweep every entry, leaving only the last end mark
				we    = 1'b1;
				waddr = clr_q[IW-1:0];
				wdata = (n != '0 && clr_q == n - CW'(1)) ? MARK_END : MARK_NONE;
				clr_d = clr_q + CW'(1);
				if (clr_q == CW'(MAXB - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				ro_d = '0;
				rb_d = '0;
				if (!cfg_ok) begin
					rs_d    = STAT_BAD_CFG;
					state_d = S_DONE;
				end else if (dflags.is_free) begin
					if (dflags.bad_off) begin
						rs_d    = STAT_BAD_OFF;
						state_d = S_DONE;
					end else begin
						seg_d   = dec_fidx;
						rd_d    = CW'(dec_fidx);
						cc_d    = '0;
						state_d = S_SEG;
					end
				end else if (dflags.too_large) begin
					rs_d    = STAT_TOO_BIG;
					state_d = S_DONE;
				end else begin
					c_d      = dec_c;
					rd_d     = '0;
					run_d    = '0;
					wok_d    = 1'b0;
					wfound_d = 1'b0;
					state_d  = S_SCAN_A;
				end
			end
			S_SCAN_A, S_SCAN_E: begin
				issue = (rd_q < n);
				if (issue) begin
					rd_d = rd_q + CW'(1);
				end
				if (v_s1) begin
					if (hit) begin
						// exact free block of the wanted size
						base_d  = j_s1 - mask;
						rd_d    = CW'(j_s1 - mask);
						state_d = S_MARK;
					end else begin
						run_d = rdata[MARK_END_BIT] ? '0 : run_n;
						wok_d = ok_n;
						if (hitw) begin
							wfound_d = 1'b1;
							wst_d    = wstart;
						end
						if (last) begin
							if (state_q == S_SCAN_A && (wfound_q || hitw)) begin
								seg_d   = hitw ? wstart : wst_q;
								rd_d    = CW'(hitw ? wstart : wst_q);
								cc_d    = '0;
								state_d = S_SEG;
							end else begin
								rs_d    = STAT_NOSPACE;
								ro_d    = '0;
								rb_d    = '0;
								state_d = S_DONE;
							end
						end
					end
				end
			end
			S_SEG: begin
				// walk to the end mark; a free also drops the allocated marks
				issue = (rd_q < n);
				if (issue) begin
					rd_d = rd_q + CW'(1);
				end
				if (v_s1) begin
					cc_d = cc_n;
					if (dflags.is_free) begin
						we    = 1'b1;
						wdata = rdata & ~MARK_ALLOC;
					end
					if (rdata[MARK_END_BIT] || last) begin
						if (dflags.is_free) begin
							rs_d  = STAT_OK;
							ro_d  = '0;
							rb_d  = 9'(cc_n);
							lw_d  = SW'(1);
							any_d = 1'b0;
							rd_d  = '0;
							state_d = (ordn == '0) ? S_DONE : S_MERGE;
						end else begin
							s_d     = SW'(1);
							state_d = S_SPLIT_RD;
						end
					end
				end
			end
			S_SPLIT_RD: begin
				// halve the segment leftward until the wanted size
				if (sh >= count) begin
					raddr   = e;
					state_d = S_SPLIT_WR;
				end else begin
					rd_d    = '0;
					run_d   = '0;
					state_d = S_SCAN_E;
				end
			end
			S_SPLIT_WR: begin
				we      = 1'b1;
				waddr   = e;
				wdata   = rdata | MARK_END;
				s_d     = s_q + SW'(1);
				state_d = S_SPLIT_RD;
			end
			S_MARK: begin
				issue = (rd_q < CW'(base_q) + count);
				if (issue) begin
					rd_d = rd_q + CW'(1);
				end
				if (v_s1) begin
					we    = 1'b1;
					wdata = rdata | MARK_ALLOC;
					if (j_s1 == base_q + mask) begin
						rs_d    = STAT_OK;
						ro_d    = 32'(base_q) << min_q;
						rb_d    = 9'(count);
						state_d = S_DONE;
					end
				end
			end
			S_MERGE: begin
				// one pass per pair width, smallest first
				issue = (rd_q < n);
				if (issue) begin
					rd_d = rd_q + CW'(1);
				end
				if (v_s1) begin
					any_d = any_n;
					if ((j_s1 & wm) == wm && rdata == MARK_END && !any_n) begin
						we    = 1'b1;
						waddr = j_s1 - IW'(w >> 1);
						wdata = MARK_NONE;
					end
					if (last) begin
						lw_d = lw_n;
						rd_d = '0;
						if (lw_n > SW'(ordn)) begin
							state_d = S_DONE;
						end
					end
				end
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
			min_q       <= 5'd8;
			heap_q      <= 6'd16;
		end else begin
			if (wr_en) begin
				// any register write reinitializes the heap
				unique case (wr_index)
					REG_MIN_ORDER:  min_q  <= wr_data[4:0];
					REG_HEAP_ORDER: heap_q <= wr_data;
					default: ;
				endcase
				state_q <= S_CLEAR;
				clr_q   <= '0;
				v_s1    <= 1'b0;
			end else begin
				state_q <= state_d;
				clr_q   <= clr_d;
				v_s1    <= issue && (state_d == state_q);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		rd_q     <= rd_d;
		j_s1     <= rd_q[IW-1:0];
		run_q    <= run_d;
		wok_q    <= wok_d;
		wfound_q <= wfound_d;
		wst_q    <= wst_d;
		seg_q    <= seg_d;
		base_q   <= base_d;
		cc_q     <= cc_d;
		s_q      <= s_d;
		any_q    <= any_d;
		lw_q     <= lw_d;
		c_q      <= c_d;
		rs_q     <= rs_d;
		ro_q     <= ro_d;
		rb_q     <= rb_d;
		if (load_out) begin
			out_status_q <= rs_q;
			out_off_q    <= ro_q;
			out_blk_q    <= rb_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign offset    = out_off_q;
	assign blocks    = out_blk_q;

endmodule
